// ===== design/frustum_containment_test_defines.svh =====
// Assertion macros shared by the frustum culling design.
`ifndef FRUSTUM_CONTAINMENT_TEST_DEFINES_SVH
`define FRUSTUM_CONTAINMENT_TEST_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked out of reset.
`define FCT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("frustum culling check failed");

// Next-cycle implication, checked out of reset.
`define FCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("frustum culling check failed");

`else

`define FCT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define FCT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/fct_pkg.sv =====
// Shared types and constants for the frustum culling pipeline.
package fct_pkg;

	localparam int NUM_PLANES      = 6;
	localparam int COORD_WIDTH_DEF = 16;
	localparam int COEF_W          = 16;
	localparam int PLANE_REG_W     = 4 * COEF_W;
	localparam int FRAC_SHIFT      = 14;
	localparam int CFG_IDX_W       = 3;
	// |a|+|b|+|c| tops out at 3 * 2^15
	localparam int ABS_SUM_W       = COEF_W + 2;

	typedef enum logic [1:0] {
		KIND_POINT  = 2'd0,
		KIND_SPHERE = 2'd1,
		KIND_CUBE   = 2'd2
	} kind_t;

	// Control word that rides along the cell chain with each beat.
	typedef struct packed {
		logic [1:0] kind;
		logic       hit;
	} fct_ctl_t;

endpackage

// ===== design/frustum_containment_test.sv =====
// Top level of the frustum culling pipeline: a chain of six plane cells.
//
// Tests a point, sphere or cube query against six frustum planes held in the
// configuration registers and returns one inside_res bit per query. The block
// takes one query per clock while in_stall is low and returns results in order
// through the six plane cells in the chain, each with a multiply stage
// and an add-and-compare stage. Each stage moves independently, so bubbles are
// squeezed out and a query enters while a finished result waits at the output.
// Plane registers are written by index (0 right, 1 left, 2 bottom, 3 top,
// 4 back, 5 front); write them only while no queries are in flight.
`include "frustum_containment_test_defines.svh"

module frustum_containment_test
	import fct_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]          cfg_idx,
	input  logic [PLANE_REG_W-1:0]        cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    kind,
	input  logic signed [COORD_WIDTH-1:0] pos_x,
	input  logic signed [COORD_WIDTH-1:0] pos_y,
	input  logic signed [COORD_WIDTH-1:0] pos_z,
	input  logic [COORD_WIDTH-2:0]        extent,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          inside_res
);

	logic [NUM_PLANES:0]           vld, rdy;
	fct_ctl_t                      ctl [NUM_PLANES+1];
	logic signed [COORD_WIDTH-1:0] px  [NUM_PLANES+1];
	logic signed [COORD_WIDTH-1:0] py  [NUM_PLANES+1];
	logic signed [COORD_WIDTH-1:0] pz  [NUM_PLANES+1];
	logic [COORD_WIDTH-2:0]        pext [NUM_PLANES+1];

	// The unused kind starts out culled and stays so.
	assign vld[0]      = in_valid;
	assign ctl[0].kind = kind;
	assign ctl[0].hit  = (kind == KIND_POINT) || (kind == KIND_SPHERE)
		|| (kind == KIND_CUBE);
	assign px[0]   = pos_x;
	assign py[0]   = pos_y;
	assign pz[0]   = pos_z;
	assign pext[0] = extent;

	for (genvar i = 0; i < NUM_PLANES; i++) begin : g_cell
		fct_cell #(
			.COORD_WIDTH(COORD_WIDTH)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cfg_sel  (cfg_wr_en && (cfg_idx == CFG_IDX_W'(i))),
			.cfg_wdata(cfg_wdata),
			.up_valid (vld[i]),
			.up_ready (rdy[i]),
			.up_ctl   (ctl[i]),
			.up_x     (px[i]),
			.up_y     (py[i]),
			.up_z     (pz[i]),
			.up_ext   (pext[i]),
			.dn_valid (vld[i+1]),
			.dn_ready (rdy[i+1]),
			.dn_ctl   (ctl[i+1]),
			.dn_x     (px[i+1]),
			.dn_y     (py[i+1]),
			.dn_z     (pz[i+1]),
			.dn_ext   (pext[i+1])
		);
	end

	assign rdy[NUM_PLANES] = !out_stall;
	assign in_stall        = !rdy[0];
	assign out_valid       = vld[NUM_PLANES];
	assign inside_res      = ctl[NUM_PLANES].hit;

	`FCT_ASSERT_IMPL(a_out_stall_blocks, clk, arst_n, out_valid && out_stall, !rdy[NUM_PLANES])
	`FCT_ASSERT_NEXT(a_bad_kind_enters_culled, clk, arst_n, in_valid && !in_stall && kind != KIND_POINT && kind != KIND_SPHERE && kind != KIND_CUBE, !g_cell[0].u_cell.ctl_s1.hit)
	`FCT_ASSERT_IMPL(a_drain_frees_input, clk, arst_n, !out_stall && !(|vld[NUM_PLANES:1]), !in_stall)

endmodule

// ===== design/fct_cell.sv =====
// One plane cell: holds a plane register and tests the passing beat against it.
`include "frustum_containment_test_defines.svh"

module fct_cell
	import fct_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_sel,
	input  logic [PLANE_REG_W-1:0]        cfg_wdata,
	input  logic                          up_valid,
	output logic                          up_ready,
	input  fct_ctl_t                      up_ctl,
	input  logic signed [COORD_WIDTH-1:0] up_x,
	input  logic signed [COORD_WIDTH-1:0] up_y,
	input  logic signed [COORD_WIDTH-1:0] up_z,
	input  logic [COORD_WIDTH-2:0]        up_ext,
	output logic                          dn_valid,
	input  logic                          dn_ready,
	output fct_ctl_t                      dn_ctl,
	output logic signed [COORD_WIDTH-1:0] dn_x,
	output logic signed [COORD_WIDTH-1:0] dn_y,
	output logic signed [COORD_WIDTH-1:0] dn_z,
	output logic [COORD_WIDTH-2:0]        dn_ext
);

	localparam int PW  = COORD_WIDTH + COEF_W;
	localparam int DW  = COEF_W + FRAC_SHIFT;
	localparam int EW  = ((PW > DW) ? PW : DW) + 3;
	localparam int TW  = COORD_WIDTH - 1 + ABS_SUM_W;

	logic [PLANE_REG_W-1:0] plane_q;

	logic signed [COEF_W-1:0] coef_a, coef_b, coef_c;
	logic signed [COEF_W:0]   a_w, b_w, c_w;
	logic [COEF_W:0]          abs_a, abs_b, abs_c;
	logic [ABS_SUM_W-1:0]     abs_sum;
	logic signed [PW-1:0]     ax_c, by_c, cz_c;
	logic [TW-1:0]            slack_c;

	logic                          v_s1, v_s2;
	fct_ctl_t                      ctl_s1, ctl_s2;
	logic signed [COORD_WIDTH-1:0] x_s1, y_s1, z_s1, x_s2, y_s2, z_s2;
	logic [COORD_WIDTH-2:0]        ext_s1, ext_s2;
	logic signed [PW-1:0]          ax_s1, by_s1, cz_s1;
	logic signed [COEF_W-1:0]      d_s1;
	logic [TW-1:0]                 slack_s1;
	logic signed [EW-1:0]          eval_c;
	logic                          en_s1, en_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= '0;
		end else if (cfg_sel) begin
			plane_q <= cfg_wdata;
		end
	end

	assign coef_a = plane_q[COEF_W-1:0];
	assign coef_b = plane_q[2*COEF_W-1:COEF_W];
	assign coef_c = plane_q[3*COEF_W-1:2*COEF_W];

	assign a_w   = (COEF_W+1)'(coef_a);
	assign b_w   = (COEF_W+1)'(coef_b);
	assign c_w   = (COEF_W+1)'(coef_c);
	assign abs_a = a_w[COEF_W] ? unsigned'(-a_w) : unsigned'(a_w);
	assign abs_b = b_w[COEF_W] ? unsigned'(-b_w) : unsigned'(b_w);
	assign abs_c = c_w[COEF_W] ? unsigned'(-c_w) : unsigned'(c_w);
	assign abs_sum = ABS_SUM_W'(abs_a) + ABS_SUM_W'(abs_b) + ABS_SUM_W'(abs_c);

	assign ax_c = PW'(coef_a) * PW'(up_x);
	assign by_c = PW'(coef_b) * PW'(up_y);
	assign cz_c = PW'(coef_c) * PW'(up_z);

	// Margin added to the center evaluation before the sign test.
	always_comb begin
		case (up_ctl.kind)
			KIND_SPHERE: slack_c = TW'(up_ext) << FRAC_SHIFT;
			KIND_CUBE:   slack_c = TW'(up_ext) * TW'(abs_sum);
			default:     slack_c = '0;
		endcase
	end

	assign eval_c = EW'(ax_s1) + EW'(by_s1) + EW'(cz_s1)
		+ (EW'(d_s1) <<< FRAC_SHIFT) + signed'(EW'(slack_s1));

	assign en_s2    = !v_s2 || dn_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign up_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= up_valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && up_valid) begin
			ctl_s1   <= up_ctl;
			x_s1     <= up_x;
			y_s1     <= up_y;
			z_s1     <= up_z;
			ext_s1   <= up_ext;
			ax_s1    <= ax_c;
			by_s1    <= by_c;
			cz_s1    <= cz_c;
			d_s1     <= plane_q[PLANE_REG_W-1:3*COEF_W];
			slack_s1 <= slack_c;
		end
		if (en_s2 && v_s1) begin
			ctl_s2.kind <= ctl_s1.kind;
			ctl_s2.hit  <= ctl_s1.hit && (eval_c > 0);
			x_s2        <= x_s1;
			y_s2        <= y_s1;
			z_s2        <= z_s1;
			ext_s2      <= ext_s1;
		end
	end

	assign dn_valid = v_s2;
	assign dn_ctl   = ctl_s2;
	assign dn_x     = x_s2;
	assign dn_y     = y_s2;
	assign dn_z     = z_s2;
	assign dn_ext   = ext_s2;

	`FCT_ASSERT_NEXT(a_hold_stalled, clk, arst_n, v_s2 && !dn_ready, v_s2 && $stable(ctl_s2))
	`FCT_ASSERT_NEXT(a_flag_never_rises, clk, arst_n, v_s1 && en_s2, !ctl_s2.hit || $past(ctl_s1.hit))
	`FCT_ASSERT_IMPL(a_ready_when_empty, clk, arst_n, !v_s1, up_ready)
	`FCT_ASSERT_IMPL(a_bad_kind_culled, clk, arst_n, v_s2 && dn_ctl.kind != KIND_POINT && dn_ctl.kind != KIND_SPHERE && dn_ctl.kind != KIND_CUBE, !dn_ctl.hit)

endmodule

// ===== bench/frustum_cull_checker.sv =====
// Checker for the frustum culling block: predicts each query verdict and compares it.
module frustum_cull_checker
	import fct_pkg::*;
(
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]             cfg_idx,
	input  logic [PLANE_REG_W-1:0]           cfg_wdata,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  logic [1:0]                       kind,
	input  logic signed [COORD_WIDTH_DEF-1:0] pos_x,
	input  logic signed [COORD_WIDTH_DEF-1:0] pos_y,
	input  logic signed [COORD_WIDTH_DEF-1:0] pos_z,
	input  logic [COORD_WIDTH_DEF-2:0]       extent,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  logic                             inside_res,
	output int                               mismatches,
	output int                               waiting
);

	logic [PLANE_REG_W-1:0] planes [NUM_PLANES];
	bit                     verdict_q [$];

	function automatic bit cull_verdict(
		input logic [1:0]                        k,
		input logic signed [COORD_WIDTH_DEF-1:0] px,
		input logic signed [COORD_WIDTH_DEF-1:0] py,
		input logic signed [COORD_WIDTH_DEF-1:0] pz,
		input logic [COORD_WIDTH_DEF-2:0]        ext
	);
		longint x, y, z, r, a, b, c, d, e, reach;
		bit     hit;
		int     p;
		x = px;
		y = py;
		z = pz;
		r = ext;
		hit = 1'b1;
		for (p = 0; p < NUM_PLANES; p++) begin
			a = $signed(planes[p][0*COEF_W +: COEF_W]);
			b = $signed(planes[p][1*COEF_W +: COEF_W]);
			c = $signed(planes[p][2*COEF_W +: COEF_W]);
			d = $signed(planes[p][3*COEF_W +: COEF_W]);
			e = a * x + b * y + c * z + (d <<< FRAC_SHIFT);
			case (k)
				KIND_POINT:  reach = e;
				KIND_SPHERE: reach = e + (r <<< FRAC_SHIFT);
				// farthest corner along the normal
				KIND_CUBE:   reach = e + r * ((a < 0 ? -a : a) + (b < 0 ? -b : b)
					+ (c < 0 ? -c : c));
				default:     reach = 0;
			endcase
			if (reach <= 0)
				hit = 1'b0;
		end
		return hit;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bit want;
		if (!arst_n) begin
			for (int p = 0; p < NUM_PLANES; p++)
				planes[p] = '0;
			verdict_q.delete();
			mismatches <= 0;
			waiting    <= 0;
		end else begin
			if (cfg_wr_en && cfg_idx < NUM_PLANES)
				planes[cfg_idx] = cfg_wdata;
			// retire the result beat before queuing a new query
			if (out_valid && !out_stall) begin
				if (verdict_q.size() == 0) begin
					$error("inside_res: expected none, got %0b", inside_res);
					mismatches <= mismatches + 1;
				end else begin
					want = verdict_q.pop_front();
					if (want !== inside_res) begin
						$error("inside_res: expected %0b, got %0b", want, inside_res);
						mismatches <= mismatches + 1;
					end
				end
			end
			if (in_valid && !in_stall)
				verdict_q.push_back(cull_verdict(kind, pos_x, pos_y, pos_z, extent));
			waiting <= verdict_q.size();
		end
	end

endmodule

// ===== bench/tb_top.sv =====
// Stimulus and verdict for the frustum culling block.
module tb_top;
	import fct_pkg::*;

	localparam logic [1:0]           KIND_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOTTOM  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TOP     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BACK    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FRONT   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_VOID_A  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_VOID_B  = 3'd7;
	localparam int                   PHASE_ITEMS = 185;

	logic                              clk;
	logic                              arst_n;
	logic                              cfg_wr_en;
	logic [CFG_IDX_W-1:0]              cfg_idx;
	logic [PLANE_REG_W-1:0]            cfg_wdata;
	logic                              in_valid;
	logic                              in_stall;
	logic [1:0]                        kind;
	logic signed [COORD_WIDTH_DEF-1:0] pos_x;
	logic signed [COORD_WIDTH_DEF-1:0] pos_y;
	logic signed [COORD_WIDTH_DEF-1:0] pos_z;
	logic [COORD_WIDTH_DEF-2:0]        extent;
	logic                              out_valid;
	logic                              out_stall;
	logic                              inside_res;
	int                                mismatches;
	int                                waiting;
	bit                                calm;
	logic [PLANE_REG_W-1:0]            plane_set [NUM_PLANES];

	frustum_containment_test i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.extent     (extent),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.inside_res (inside_res)
	);

	frustum_cull_checker i_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.extent     (extent),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.inside_res (inside_res),
		.mismatches (mismatches),
		.waiting    (waiting)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= !calm && ($urandom_range(99) < 14);
	end

	function automatic logic [PLANE_REG_W-1:0] pack_plane(
		input logic [COEF_W-1:0] a,
		input logic [COEF_W-1:0] b,
		input logic [COEF_W-1:0] c,
		input logic [COEF_W-1:0] d
	);
		return {d, c, b, a};
	endfunction

	function automatic logic [COORD_WIDTH_DEF-1:0] pick_coord(input int span);
		int t;
		if ($urandom_range(0, 3) == 0)
			t = $urandom;
		else
			t = int'($urandom_range(0, 2 * span)) - span;
		return t[COORD_WIDTH_DEF-1:0];
	endfunction

	function automatic logic [COORD_WIDTH_DEF-2:0] pick_extent(input int span);
		int t;
		if ($urandom_range(0, 3) == 0)
			t = $urandom_range(0, 32767);
		else
			t = $urandom_range(0, span / 2);
		return t[COORD_WIDTH_DEF-2:0];
	endfunction

	function automatic logic [COEF_W-1:0] pick_extreme();
		case ($urandom_range(0, 2))
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			default: return 16'h0000;
		endcase
	endfunction

	// Leaves in_valid high after the beat is taken.
	task automatic send_query(
		input logic [1:0]                 k,
		input logic [COORD_WIDTH_DEF-1:0] x,
		input logic [COORD_WIDTH_DEF-1:0] y,
		input logic [COORD_WIDTH_DEF-1:0] z,
		input logic [COORD_WIDTH_DEF-2:0] r
	);
		if (!calm && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind     <= k;
		pos_x    <= x;
		pos_y    <= y;
		pos_z    <= z;
		extent   <= r;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic random_query(input int span);
		logic [1:0] k;
		int         pick;
		pick = $urandom_range(0, 9);
		if (pick < 3)
			k = KIND_POINT;
		else if (pick < 6)
			k = KIND_SPHERE;
		else if (pick < 9)
			k = KIND_CUBE;
		else
			k = KIND_UNUSED;
		send_query(k, pick_coord(span), pick_coord(span), pick_coord(span), pick_extent(span));
	endtask

	// Hold input low until every queued verdict has come back.
	task automatic drain_queries();
		in_valid <= 1'b0;
		do @(posedge clk); while (waiting != 0);
	endtask

	// Write plane_set, with ignored writes to the unused indexes mixed in.
	task automatic load_planes();
		cfg_wr_en <= 1'b1;
		cfg_idx   <= REG_VOID_A;
		cfg_wdata <= {$urandom, $urandom};
		@(posedge clk);
		for (int p = 0; p < NUM_PLANES; p++) begin
			cfg_idx   <= p[CFG_IDX_W-1:0];
			cfg_wdata <= plane_set[p];
			@(posedge clk);
		end
		cfg_idx   <= REG_VOID_B;
		cfg_wdata <= {$urandom, $urandom};
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Axis-aligned box, half sizes in Q8.8; scale sets the normal length.
	task automatic build_box(input logic [COEF_W-1:0] scale, input int hx, input int hy,
		input int hz);
		logic [COEF_W-1:0] neg;
		neg = -scale;
		plane_set[REG_RIGHT]  = pack_plane(neg, 16'h0, 16'h0, hx[COEF_W-1:0]);
		plane_set[REG_LEFT]   = pack_plane(scale, 16'h0, 16'h0, hx[COEF_W-1:0]);
		plane_set[REG_BOTTOM] = pack_plane(16'h0, scale, 16'h0, hy[COEF_W-1:0]);
		plane_set[REG_TOP]    = pack_plane(16'h0, neg, 16'h0, hy[COEF_W-1:0]);
		plane_set[REG_BACK]   = pack_plane(16'h0, 16'h0, neg, hz[COEF_W-1:0]);
		plane_set[REG_FRONT]  = pack_plane(16'h0, 16'h0, scale, hz[COEF_W-1:0]);
	endtask

	initial begin
		#2000000;
		$display("tb_top: errors");
		$finish;
	end

	initial begin
		logic [COEF_W-1:0] s;
		arst_n    <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_idx   <= REG_RIGHT;
		cfg_wdata <= '0;
		in_valid  <= 1'b0;
		kind      <= KIND_POINT;
		pos_x     <= '0;
		pos_y     <= '0;
		pos_z     <= '0;
		extent    <= '0;
		calm      = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// planes straight out of reset: every center evaluation is zero
		send_query(KIND_POINT, 16'h0000, 16'h0000, 16'h0000, 15'h0000);
		send_query(KIND_SPHERE, 16'h0100, 16'h0000, 16'h0000, 15'h0000);
		send_query(KIND_SPHERE, 16'h0000, 16'h8000, 16'h0000, 15'h0001);
		send_query(KIND_CUBE, 16'h7FFF, 16'h0000, 16'h0000, 15'h7FFF);
		send_query(KIND_UNUSED, 16'h0000, 16'h0000, 16'h0000, 15'h0010);
		drain_queries();

		// unit box of half size 10.0; touch cases sit right on a face
		build_box(16'd16384, 2560, 2560, 2560);
		load_planes();
		send_query(KIND_POINT, 16'h0000, 16'h0000, 16'h0000, 15'h0000);
		send_query(KIND_POINT, 16'd2560, 16'h0000, 16'h0000, 15'h7FFF);
		send_query(KIND_POINT, 16'd2559, 16'h0000, 16'h0000, 15'h0000);
		send_query(KIND_SPHERE, 16'd2660, 16'h0000, 16'h0000, 15'd101);
		send_query(KIND_SPHERE, 16'd2660, 16'h0000, 16'h0000, 15'd100);
		send_query(KIND_CUBE, 16'h0000, 16'd2660, 16'h0000, 15'd101);
		send_query(KIND_CUBE, 16'h0000, 16'h0000, 16'd2660, 15'd100);
		send_query(KIND_POINT, 16'h7FFF, 16'h7FFF, 16'h7FFF, 15'h0000);
		send_query(KIND_POINT, 16'h8000, 16'h8000, 16'h8000, 15'h0000);
		send_query(KIND_SPHERE, 16'h8000, 16'h8000, 16'h8000, 15'h7FFF);
		send_query(KIND_CUBE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 15'h7FFF);
		send_query(KIND_UNUSED, 16'h0000, 16'h0000, 16'h0000, 15'h7FFF);
		drain_queries();

		for (int ph = 0; ph < 4; ph++) begin
			calm = (ph == 1);
			case (ph)
				0: build_box(16'd16384, $urandom_range(256, 16'h1800),
					$urandom_range(256, 16'h1800), $urandom_range(256, 16'h1800));
				1: begin
					for (int p = 0; p < NUM_PLANES; p++)
						plane_set[p] = {$urandom, $urandom};
				end
				2: begin
					s = COEF_W'($urandom_range(1, 32767));
					build_box(s, $urandom_range(0, 16'h7FFF), $urandom_range(256, 16'h1800),
						$urandom_range(0, 16'h1800));
				end
				default: begin
					for (int p = 0; p < NUM_PLANES; p++)
						plane_set[p] = pack_plane(pick_extreme(), pick_extreme(),
							pick_extreme(), $urandom_range(0, 1) ? 16'h7FFF : 16'h8000);
				end
			endcase
			load_planes();
			for (int n = 0; n < PHASE_ITEMS; n++)
				random_query(ph == 1 ? 16'h2000 : 16'h1C00);
			drain_queries();
		end

		calm = 1'b0;
		repeat (20) @(posedge clk);
		if (mismatches == 0 && waiting == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
